/* sv/porm_pkg.sv */
// ----------------------------------------------------------------------------
// porm_pkg
// Shared types and constants of the polar outline radius morph block.
// ----------------------------------------------------------------------------
package porm_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam logic [29:0] CORDIC_K = 30'd652032874;

   localparam int UNIT_W     = 18;
   localparam int LEN_W      = 18;
   localparam int DIVIDEND_W = 50;
   localparam int DIVISOR_W  = 36;
   localparam int QUOT_W     = 31;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SAT   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [1:0] CSR_PROGRESS     = 2'd0;
   localparam logic [1:0] CSR_FROM_PRESENT = 2'd1;
   localparam logic [1:0] CSR_TO_PRESENT   = 2'd2;

   typedef struct packed {
      logic start;
      logic vector_mode;
   } cordic_ctl_type;

   function automatic logic [29:0] atan_entry(input logic [4:0] step);
      logic [29:0] value;
      case (step)
         5'd0:  value = 30'd536870912;
         5'd1:  value = 30'd316933406;
         5'd2:  value = 30'd167458907;
         5'd3:  value = 30'd85004756;
         5'd4:  value = 30'd42667331;
         5'd5:  value = 30'd21354465;
         5'd6:  value = 30'd10679838;
         5'd7:  value = 30'd5340245;
         5'd8:  value = 30'd2670163;
         5'd9:  value = 30'd1335087;
         5'd10: value = 30'd667544;
         5'd11: value = 30'd333772;
         5'd12: value = 30'd166886;
         5'd13: value = 30'd83443;
         5'd14: value = 30'd41722;
         5'd15: value = 30'd20861;
         5'd16: value = 30'd10430;
         5'd17: value = 30'd5215;
         5'd18: value = 30'd2608;
         5'd19: value = 30'd1304;
         5'd20: value = 30'd652;
         5'd21: value = 30'd326;
         5'd22: value = 30'd163;
         5'd23: value = 30'd81;
         default: value = 30'd0;
      endcase
      return value;
   endfunction

endpackage

/* sv/porm_cordic.sv */
// ----------------------------------------------------------------------------
// porm_cordic
// Iterative CORDIC unit: rotation gives the unit ray vector, vectoring gives
// the magnitude of a point, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module porm_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  porm_pkg::cordic_ctl_type            ctl,
   input  logic [31:0]                         phase,
   input  logic signed [15:0]                  vec_x,
   input  logic signed [15:0]                  vec_y,
   output logic                                done,
   output logic signed [porm_pkg::UNIT_W-1:0]  cos_out,
   output logic signed [porm_pkg::UNIT_W-1:0]  sin_out,
   output logic [porm_pkg::LEN_W-1:0]          length
);
   import porm_pkg::*;

   typedef enum logic [1:0] {C_IDLE, C_ITER, C_FIN, C_MUL_HI} cstate_type;

   cstate_type          state_ff;
   logic [4:0]          step_ff;
   logic                vector_ff;
   logic [1:0]          quad_ff;
   logic signed [35:0]  x_ff;
   logic signed [35:0]  y_ff;
   logic signed [32:0]  z_ff;
   logic [63:0]         acc_ff;
   logic                done_ff;
   logic signed [UNIT_W-1:0] cos_ff;
   logic signed [UNIT_W-1:0] sin_ff;
   logic [LEN_W-1:0]    length_ff;

   logic signed [35:0]  x_shift;
   logic signed [35:0]  y_shift;
   logic                plus;
   logic signed [35:0]  x_iter_in;
   logic signed [35:0]  y_iter_in;
   logic signed [32:0]  z_iter_in;
   logic signed [32:0]  atan_w;
   logic signed [35:0]  cc_w;
   logic signed [35:0]  ss_w;
   logic signed [UNIT_W-1:0] cc;
   logic signed [UNIT_W-1:0] ss;
   logic signed [35:0]  abs_x;
   logic signed [35:0]  abs_y;
   logic [16:0]         mul_op;
   logic [46:0]         mul_p;
   logic [63:0]         acc_hi_in;

   always_comb begin
      x_shift   = x_ff >>> step_ff;
      y_shift   = y_ff >>> step_ff;
      plus      = vector_ff ? !y_ff[35] : z_ff[32];
      atan_w    = signed'({3'b000, atan_entry(step_ff)});
      x_iter_in = plus ? x_ff + y_shift : x_ff - y_shift;
      y_iter_in = plus ? y_ff - x_shift : y_ff + x_shift;
      z_iter_in = plus ? z_ff + atan_w : z_ff - atan_w;
      cc_w      = (x_ff + 36'sd16384) >>> 15;
      ss_w      = (y_ff + 36'sd16384) >>> 15;
      cc        = cc_w[UNIT_W-1:0];
      ss        = ss_w[UNIT_W-1:0];
      abs_x     = vec_x[15] ? -36'(vec_x) : 36'(vec_x);
      abs_y     = vec_y[15] ? -36'(vec_y) : 36'(vec_y);
      mul_op    = (state_ff == C_FIN) ? x_ff[16:0] : {1'b0, x_ff[32:17]};
      mul_p     = 47'(mul_op) * 47'(CORDIC_K);
      acc_hi_in = acc_ff + (64'(mul_p) << 17);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               if (ctl.start) begin
                  vector_ff <= ctl.vector_mode;
                  step_ff   <= 5'd0;
                  quad_ff   <= phase[31:30];
                  if (ctl.vector_mode) begin
                     x_ff <= abs_x <<< 16;
                     y_ff <= abs_y <<< 16;
                     z_ff <= '0;
                  end else begin
                     x_ff <= 36'(CORDIC_K);
                     y_ff <= '0;
                     z_ff <= signed'({3'b000, phase[29:0]});
                  end
                  state_ff <= C_ITER;
               end
            end
            C_ITER: begin
               x_ff <= x_iter_in;
               y_ff <= y_iter_in;
               z_ff <= z_iter_in;
               if (step_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= C_FIN;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            C_FIN: begin
               if (vector_ff) begin
                  acc_ff   <= 64'(mul_p);
                  state_ff <= C_MUL_HI;
               end else begin
                  case (quad_ff)
                     2'd0: begin cos_ff <= cc;  sin_ff <= ss;  end
                     2'd1: begin cos_ff <= -ss; sin_ff <= cc;  end
                     2'd2: begin cos_ff <= -cc; sin_ff <= -ss; end
                     default: begin cos_ff <= ss; sin_ff <= -cc; end
                  endcase
                  done_ff  <= 1'b1;
                  state_ff <= C_IDLE;
               end
            end
            C_MUL_HI: begin
               length_ff <= acc_hi_in[63:64-LEN_W];
               done_ff   <= 1'b1;
               state_ff  <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
   assign length  = length_ff;

   a_magnitude_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_MUL_HI) |-> !x_ff[35])
      else $error("vectoring magnitude went negative");
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_ITER) |-> (step_ff < 5'(CORDIC_STEPS)))
      else $error("CORDIC step counter overran");
   a_done_after_work: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff == C_FIN || state_ff == C_MUL_HI))
      else $error("CORDIC done without finishing");

endmodule

/* sv/porm_divider.sv */
// ----------------------------------------------------------------------------
// porm_divider
// Restoring divider, one quotient bit per cycle, with the quotient clamped
// to 31 bits by a compare at start.
// ----------------------------------------------------------------------------
module porm_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [porm_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [porm_pkg::DIVISOR_W-1:0]       divisor,
   output logic                                 done,
   output logic [porm_pkg::QUOT_W-1:0]          quotient
);
   import porm_pkg::*;

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type             state_ff;
   logic [DIVISOR_W-1:0]   rem_ff;
   logic [QUOT_W-1:0]      bits_ff;
   logic [QUOT_W-1:0]      quot_ff;
   logic [4:0]             count_ff;
   logic                   done_ff;

   logic [DIVISOR_W:0]     trial;
   logic                   fits;
   logic [DIVISOR_W:0]     trial_sub;
   logic [DIVISOR_W-1:0]   head;

   always_comb begin
      head      = DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
      trial     = {rem_ff, bits_ff[QUOT_W-1]};
      fits      = trial >= {1'b0, divisor};
      trial_sub = trial - {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  if (head >= divisor) begin
                     quot_ff <= '1;
                     done_ff <= 1'b1;
                  end else begin
                     rem_ff   <= head;
                     bits_ff  <= dividend[QUOT_W-1:0];
                     count_ff <= 5'd0;
                     state_ff <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               rem_ff  <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
               quot_ff <= {quot_ff[QUOT_W-2:0], fits};
               bits_ff <= {bits_ff[QUOT_W-2:0], 1'b0};
               if (count_ff == 5'(QUOT_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  count_ff <= count_ff + 5'd1;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_RUN) |-> (rem_ff < divisor))
      else $error("partial remainder reached the divisor");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_RUN) |-> (count_ff < 5'(QUOT_W)))
      else $error("divider step counter overran");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_RUN) |-> !done_ff)
      else $error("divider signalled done while still running");

endmodule

/* sv/polar_outline_radius_morph.sv */
// ----------------------------------------------------------------------------
// polar_outline_radius_morph
// Radius of a morphing star-shaped outline along a ray, from two stored
// polygons cut by the ray and blended by a progress fraction.
// ----------------------------------------------------------------------------
// A load item writes one outline point; the block stays ready for the next
// item. A query item first runs the CORDIC rotation that gives the ray
// vector. Then, for each present non-empty outline, it reads the first
// stored angle and runs an angle search. Each step of the search is one
// memory read and one compare, and there are at most one more steps than
// log2 of the point count, rounded down. It then does the edge fetch and
// cross products on the shared multiplier, and either the divider run or
// two CORDIC magnitude runs when the ray is parallel to the edge. A
// handover state then passes on to the next outline. An empty outline goes
// straight to the handover state and an absent one ends in the slot state.
// The blend and output states follow. The query time is set by the CORDIC
// step loop and the one-bit-per-cycle divider. The block takes no new item
// while a query is in flight. A finished result waits in the output
// register and does not hold up the next item; only a second finished
// result waits for the first to leave. Outline memories are not cleared;
// points inside a count must be loaded before they are queried.
// ----------------------------------------------------------------------------
module polar_outline_radius_morph #(
   parameter int MAX_POINTS = 1024,
   parameter int FRAC_BITS  = 14,
   parameter int ANGLE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // slot[0], point_index[10:1], point_x[26:11], point_y[42:27],
   // point_angle[60:43], query_angle[76:61], zero padding above
   input  logic [79:0]  req_tdata,
   // req_type[0]
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // radius[14:0], status[16:15], zero padding above
   output logic [23:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import porm_pkg::*;

   localparam int AW = $clog2(2 * MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int TW = ((ANGLE_BITS > 17) ? ANGLE_BITS : 17) + 2;
   localparam logic [31:0] AMASK32 = (32'd1 << ANGLE_BITS) - 32'd1;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_ROT_GO, S_ROT, S_SLOT, S_A0_RD, S_A0, S_SRCH, S_CMP,
      S_P_RD, S_Q_RD, S_Q, S_M0, S_M1, S_M2, S_M3, S_DIV_GO, S_DIV,
      S_LP_GO, S_LP, S_LQ_GO, S_LQ, S_NEXT, S_BL0, S_BL1, S_OUT
   } state_type;

   logic signed [15:0] outline_x_mem [2*MAX_POINTS];
   logic signed [15:0] outline_y_mem [2*MAX_POINTS];
   logic signed [17:0] outline_angle_mem [2*MAX_POINTS];

   state_type            state_ff;
   logic                 slot_ff;
   logic [15:0]          q_ff;
   logic                 empty_ff;
   logic signed [15:0]   progress_ff;
   logic                 from_present_ff;
   logic                 to_present_ff;
   logic [CW-1:0]        count_ff [2];
   logic signed [TW-1:0] t_ff;
   logic [CW-1:0]        lo_ff;
   logic [CW-1:0]        len_ff;
   logic [CW-1:0]        half_ff;
   logic signed [15:0]   rd_x_ff;
   logic signed [15:0]   rd_y_ff;
   logic signed [17:0]   rd_angle_ff;
   logic signed [UNIT_W-1:0] ux_ff;
   logic signed [UNIT_W-1:0] uy_ff;
   logic signed [15:0]   px_ff;
   logic signed [15:0]   py_ff;
   logic signed [15:0]   qx_ff;
   logic signed [15:0]   qy_ff;
   logic signed [51:0]   acc_ff;
   logic signed [35:0]   den_ff;
   logic signed [35:0]   num_ff;
   logic [LEN_W-1:0]     lp_ff;
   logic signed [31:0]   r_ff;
   logic signed [31:0]   a_ff;
   logic signed [31:0]   b_ff;
   logic [14:0]          res_radius_ff;
   logic [1:0]           res_status_ff;
   logic                 rsp_valid_ff;
   logic [14:0]          rsp_radius_ff;
   logic [1:0]           rsp_status_ff;

   logic                 req_slot;
   logic [9:0]           req_index;
   logic signed [15:0]   req_x;
   logic signed [15:0]   req_y;
   logic signed [17:0]   req_angle;
   logic [15:0]          req_query;
   logic                 load_ok;
   logic                 load_we;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic [31:0]          base32;
   logic [31:0]          rd_addr32;
   logic [CW-1:0]        n_w;
   logic [CW-1:0]        half_w;
   logic [CW-1:0]        ip_w;
   logic [CW-1:0]        iq_w;
   logic signed [31:0]   a0_w;
   logic [31:0]          off_w;
   logic signed [TW-1:0] t_in;
   logic signed [16:0]   ex_w;
   logic signed [16:0]   ey_w;
   logic signed [33:0]   mul_a;
   logic signed [17:0]   mul_b;
   logic signed [51:0]   mul_p;
   logic signed [51:0]   acc_sub;
   logic [35:0]          abs_num;
   logic [DIVIDEND_W-1:0] mn_w;
   logic [DIVISOR_W-1:0] md_w;
   logic signed [52:0]   blend_w;
   logic [31:0]          phase_w;
   logic                 result_neg;

   cordic_ctl_type       cord_ctl;
   logic signed [15:0]   cord_vx;
   logic signed [15:0]   cord_vy;
   logic                 cord_done;
   logic signed [UNIT_W-1:0] cord_cos;
   logic signed [UNIT_W-1:0] cord_sin;
   logic [LEN_W-1:0]     cord_len;
   logic                 div_start;
   logic                 div_done;
   logic [QUOT_W-1:0]    div_quot;

   always_comb begin
      req_slot  = req_tdata[0];
      req_index = req_tdata[10:1];
      req_x     = signed'(req_tdata[26:11]);
      req_y     = signed'(req_tdata[42:27]);
      req_angle = signed'(req_tdata[60:43]);
      req_query = req_tdata[76:61];
      load_ok   = 32'(req_index) < 32'(MAX_POINTS);
      load_we   = req_tvalid && req_tready && (req_tuser == REQ_LOAD) && load_ok;
      wr_addr   = AW'(32'(req_index) + (req_slot ? 32'(MAX_POINTS) : 32'd0));

      base32 = slot_ff ? 32'(MAX_POINTS) : 32'd0;
      n_w    = count_ff[slot_ff];
      half_w = len_ff >> 1;
      ip_w   = (lo_ff == '0) ? n_w - CW'(1) : lo_ff - CW'(1);
      iq_w   = (lo_ff == n_w) ? '0 : lo_ff;
      case (state_ff)
         S_SRCH: rd_addr32 = base32 + 32'(lo_ff) + 32'(half_w);
         S_P_RD: rd_addr32 = base32 + 32'(ip_w);
         S_Q_RD: rd_addr32 = base32 + 32'(iq_w);
         default: rd_addr32 = base32;
      endcase
      rd_addr = rd_addr32[AW-1:0];

      a0_w  = 32'(rd_angle_ff);
      off_w = (32'(q_ff) - 32'(a0_w)) & AMASK32;
      t_in  = TW'(a0_w + signed'(off_w));

      ex_w = 17'(qx_ff) - 17'(px_ff);
      ey_w = 17'(qy_ff) - 17'(py_ff);
      case (state_ff)
         S_M0: begin mul_a = 34'(ey_w); mul_b = ux_ff; end
         S_M1: begin mul_a = 34'(ex_w); mul_b = uy_ff; end
         S_M2: begin mul_a = 34'(ey_w); mul_b = 18'(px_ff); end
         S_M3: begin mul_a = 34'(ex_w); mul_b = 18'(py_ff); end
         default: begin mul_a = 34'(b_ff) - 34'(a_ff); mul_b = 18'(progress_ff); end
      endcase
      mul_p   = mul_a * mul_b;
      acc_sub = acc_ff - mul_p;

      abs_num    = num_ff[35] ? 36'(-num_ff) : 36'(num_ff);
      mn_w       = {abs_num[DIVIDEND_W-16:0], 15'd0};
      md_w       = den_ff[35] ? DIVISOR_W'(-den_ff) : DIVISOR_W'(den_ff);
      result_neg = num_ff[35] ^ den_ff[35];

      blend_w = 53'(a_ff) + 53'(acc_ff >>> FRAC_BITS);
      phase_w = 32'(q_ff) << (32 - ANGLE_BITS);

      cord_ctl.start       = (state_ff == S_ROT_GO) || (state_ff == S_LP_GO) ||
                             (state_ff == S_LQ_GO);
      cord_ctl.vector_mode = (state_ff != S_ROT_GO);
      cord_vx   = (state_ff == S_LQ_GO) ? qx_ff : px_ff;
      cord_vy   = (state_ff == S_LQ_GO) ? qy_ff : py_ff;
      div_start = (state_ff == S_DIV_GO);
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         outline_x_mem[wr_addr] <= req_x;
      end
      rd_x_ff <= outline_x_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         outline_y_mem[wr_addr] <= req_y;
      end
      rd_y_ff <= outline_y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         outline_angle_mem[wr_addr] <= req_angle;
      end
      rd_angle_ff <= outline_angle_mem[rd_addr];
   end

   porm_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cord_ctl),
      .phase   (phase_w),
      .vec_x   (cord_vx),
      .vec_y   (cord_vy),
      .done    (cord_done),
      .cos_out (cord_cos),
      .sin_out (cord_sin),
      .length  (cord_len)
   );

   porm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mn_w),
      .divisor  (md_w),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         count_ff[0]     <= '0;
         count_ff[1]     <= '0;
         progress_ff     <= '0;
         from_present_ff <= 1'b1;
         to_present_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROGRESS:     progress_ff     <= signed'(csr_wdata);
               CSR_FROM_PRESENT: from_present_ff <= csr_wdata[0];
               CSR_TO_PRESENT:   to_present_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  if (req_tuser == REQ_QUERY) begin
                     q_ff     <= 16'(32'(req_query) & AMASK32);
                     empty_ff <= 1'b0;
                     slot_ff  <= 1'b0;
                     state_ff <= S_ROT_GO;
                  end else if (load_ok && req_tlast) begin
                     count_ff[req_slot] <= CW'(32'(req_index) + 32'd1);
                  end
               end
            end
            S_ROT_GO: state_ff <= S_ROT;
            S_ROT: begin
               if (cord_done) begin
                  ux_ff    <= cord_cos;
                  uy_ff    <= cord_sin;
                  state_ff <= S_SLOT;
               end
            end
            S_SLOT: begin
               if (!slot_ff && !from_present_ff) begin
                  a_ff    <= ONE;
                  slot_ff <= 1'b1;
               end else if (slot_ff && !to_present_ff) begin
                  b_ff     <= a_ff;
                  state_ff <= S_BL0;
               end else if (n_w == '0) begin
                  r_ff     <= ONE;
                  empty_ff <= 1'b1;
                  state_ff <= S_NEXT;
               end else begin
                  state_ff <= S_A0_RD;
               end
            end
            S_A0_RD: state_ff <= S_A0;
            S_A0: begin
               t_ff     <= t_in;
               lo_ff    <= '0;
               len_ff   <= n_w;
               state_ff <= S_SRCH;
            end
            S_SRCH: begin
               if (len_ff == '0) begin
                  state_ff <= S_P_RD;
               end else begin
                  half_ff  <= half_w;
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (t_ff < TW'(rd_angle_ff)) begin
                  len_ff <= half_ff;
               end else begin
                  lo_ff  <= lo_ff + half_ff + CW'(1);
                  len_ff <= len_ff - half_ff - CW'(1);
               end
               state_ff <= S_SRCH;
            end
            S_P_RD: state_ff <= S_Q_RD;
            S_Q_RD: begin
               px_ff    <= rd_x_ff;
               py_ff    <= rd_y_ff;
               state_ff <= S_Q;
            end
            S_Q: begin
               qx_ff    <= rd_x_ff;
               qy_ff    <= rd_y_ff;
               state_ff <= S_M0;
            end
            S_M0: begin
               acc_ff   <= mul_p;
               state_ff <= S_M1;
            end
            S_M1: begin
               den_ff   <= acc_sub[35:0];
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff   <= mul_p;
               state_ff <= S_M3;
            end
            S_M3: begin
               num_ff   <= acc_sub[35:0];
               state_ff <= (den_ff == '0) ? S_LP_GO : S_DIV_GO;
            end
            S_DIV_GO: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  r_ff     <= result_neg ? -32'({1'b0, div_quot}) : 32'({1'b0, div_quot});
                  state_ff <= S_NEXT;
               end
            end
            S_LP_GO: state_ff <= S_LP;
            S_LP: begin
               if (cord_done) begin
                  lp_ff    <= cord_len;
                  state_ff <= S_LQ_GO;
               end
            end
            S_LQ_GO: state_ff <= S_LQ;
            S_LQ: begin
               if (cord_done) begin
                  r_ff     <= 32'((lp_ff < cord_len) ? lp_ff : cord_len);
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (!slot_ff) begin
                  a_ff     <= r_ff;
                  slot_ff  <= 1'b1;
                  state_ff <= S_SLOT;
               end else begin
                  b_ff     <= r_ff;
                  state_ff <= S_BL0;
               end
            end
            S_BL0: begin
               acc_ff   <= mul_p;
               state_ff <= S_BL1;
            end
            S_BL1: begin
               if (blend_w < 0) begin
                  res_radius_ff <= '0;
                  res_status_ff <= empty_ff ? STATUS_EMPTY : STATUS_OK;
               end else if (blend_w > 53'sd32767) begin
                  res_radius_ff <= 15'h7FFF;
                  res_status_ff <= STATUS_SAT;
               end else begin
                  res_radius_ff <= blend_w[14:0];
                  res_status_ff <= empty_ff ? STATUS_EMPTY : STATUS_OK;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_radius_ff <= res_radius_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_radius_ff};

   a_cordic_done_waited: assert property (@(posedge clock) disable iff (reset)
      cord_done |-> (state_ff == S_ROT || state_ff == S_LP || state_ff == S_LQ))
      else $error("CORDIC result arrived outside a wait state");
   a_divider_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider result arrived outside its wait state");
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> ((32'(lo_ff) + 32'(len_ff)) <= 32'(n_w)))
      else $error("search window ran past the outline count");
   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished result was not placed in the output register");

endmodule
